// ----- rtl/bqf_pkg.sv -----
// Shared types, constants and the microcode program of the biquad IIR filter.
package bqf_pkg;

  // Default field widths and the coefficient format (sign plus three integer bits).
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned COEFF_WIDTH_DEF  = 24;
  localparam int unsigned COEFF_INT_BITS   = 4;

  // Configuration port index width.
  localparam int unsigned CFG_INDEX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BYPASS    = 3'd0,
    CFG_FF_GAIN_0 = 3'd1,
    CFG_FF_GAIN_1 = 3'd2,
    CFG_FF_GAIN_2 = 3'd3,
    CFG_FB_GAIN_1 = 3'd4,
    CFG_FB_GAIN_2 = 3'd5
  } cfg_index_e;

  // Program counter width and the step addresses of the program.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_FF0 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ACC_D1  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_TMP_D1  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ROUND   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SAT     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_FB1     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_FB2     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_BYPASS  = 4'd9;

  // Multiplier operand selection; hold keeps the product register.
  typedef enum logic [2:0] {
    MUL_HOLD,
    MUL_X_FF0,
    MUL_X_FF1,
    MUL_X_FF2,
    MUL_Y_FB1,
    MUL_Y_FB2
  } mul_sel_e;

  // Saturating adder operation and destination.
  typedef enum logic [2:0] {
    ADD_NONE,
    ADD_PROD_D1,
    ADD_ACC_HALF,
    ADD_PROD_D2,
    ADD_D1_SUB,
    ADD_D2_SUB
  } add_op_e;

  // Output sample register update.
  typedef enum logic [1:0] {
    Y_HOLD,
    Y_ROUND,
    Y_PASS
  } y_op_e;

  // Sequencer branch condition.
  typedef enum logic [1:0] {
    JMP_GO,
    JMP_WAIT_IN,
    JMP_IF_BYPASS,
    JMP_WAIT_OUT
  } jump_e;

  // One control word of the program.
  typedef struct packed {
    logic              take_in;
    mul_sel_e          mul;
    add_op_e           add;
    logic              d2_load;
    y_op_e             y_op;
    logic              emit;
    jump_e             jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Conditions that the datapath and the ports report to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic bypass;
    logic out_busy;
  } status_t;

  // Program ROM: one control word per step.
  function automatic ctrl_t ucode_word(logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{take_in: 1'b0, mul: MUL_HOLD, add: ADD_NONE, d2_load: 1'b0, y_op: Y_HOLD,
          emit: 1'b0, jmp: JMP_GO, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.jmp     = JMP_WAIT_IN;
        w.target  = STEP_MUL_FF0;
      end
      STEP_MUL_FF0: begin
        w.mul    = MUL_X_FF0;
        w.y_op   = Y_PASS;
        w.jmp    = JMP_IF_BYPASS;
        w.target = STEP_BYPASS;
      end
      STEP_ACC_D1: begin
        w.mul    = MUL_X_FF1;
        w.add    = ADD_PROD_D1;
        w.target = STEP_TMP_D1;
      end
      STEP_TMP_D1: begin
        w.mul    = MUL_X_FF2;
        w.add    = ADD_PROD_D2;
        w.target = STEP_ROUND;
      end
      STEP_ROUND: begin
        w.add     = ADD_ACC_HALF;
        w.d2_load = 1'b1;
        w.target  = STEP_SAT;
      end
      STEP_SAT: begin
        w.y_op   = Y_ROUND;
        w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.mul    = MUL_Y_FB1;
        w.emit   = 1'b1;
        w.jmp    = JMP_WAIT_OUT;
        w.target = STEP_FB1;
      end
      STEP_FB1: begin
        w.mul    = MUL_Y_FB2;
        w.add    = ADD_D1_SUB;
        w.target = STEP_FB2;
      end
      STEP_FB2: begin
        w.add    = ADD_D2_SUB;
        w.target = STEP_IDLE;
      end
      STEP_BYPASS: begin
        w.emit   = 1'b1;
        w.jmp    = JMP_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/bqf_if.sv -----
// Stream channel interfaces for input samples and filtered results.
interface bqf_sample_if import bqf_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface bqf_result_if import bqf_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

// ----- rtl/biquad_iir_filter.sv -----
// Top level of the biquad IIR filter section.
//
//   Channel  Dir  Handshake          Payload
//   in_i     in   valid/ready        sample_in (signed SAMPLE_WIDTH)
//   out_o    out  valid/ready        sample_out (signed SAMPLE_WIDTH), clipped
//   cfg      in   cfg_we_i, no wait  cfg_index_i, cfg_data_i (COEFF_WIDTH)
//
// A filtered item runs steps 1 to 8 of the program through the one shared multiplier,
// five products in turn, before the next item is accepted; a bypassed item runs steps
// 1 and 9. The result enters the output register at the emit step (bypass: step 9);
// a waiting result blocks only the next item's emit step.
// Reset clears the delays, selects bypass and loads unity gain into ff_gain_0.
// While the output register is full and not taken, the program holds at its
// emit step.
module biquad_iir_filter import bqf_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEFF_WIDTH  = COEFF_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bqf_sample_if.sink             in_i,
  bqf_result_if.source           out_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [COEFF_WIDTH-1:0] cfg_data_i
);

  logic                          bypass;
  logic signed [COEFF_WIDTH-1:0] ff0, ff1, ff2, fb1, fb2;
  ctrl_t                         ctrl;
  status_t                       status;
  logic                          out_busy;

  // Configuration registers.
  bqf_regs #(
    .COEFF_WIDTH(COEFF_WIDTH)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .bypass_o   (bypass),
    .ff0_o      (ff0),
    .ff1_o      (ff1),
    .ff2_o      (ff2),
    .fb1_o      (fb1),
    .fb2_o      (fb2)
  );

  // Sequencer status.
  assign status = '{in_valid: in_i.valid, bypass: bypass, out_busy: out_busy};

  bqf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  // Input is taken only in the idle step of the program.
  assign in_i.ready = ctrl.take_in;

  bqf_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_i.valid),
    .sample_i    (in_i.sample_in),
    .ff0_i       (ff0),
    .ff1_i       (ff1),
    .ff2_i       (ff2),
    .fb1_i       (fb1),
    .fb2_i       (fb2),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sample_out_o(out_o.sample_out),
    .clipped_o   (out_o.clipped),
    .out_busy_o  (out_busy)
  );

endmodule

// ----- rtl/bqf_regs.sv -----
// Configuration register file: bypass flag and the five filter coefficients.
module bqf_regs import bqf_pkg::*; #(
  parameter int unsigned COEFF_WIDTH = COEFF_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [COEFF_WIDTH-1:0]        cfg_data_i,
  output logic                          bypass_o,
  output logic signed [COEFF_WIDTH-1:0] ff0_o,
  output logic signed [COEFF_WIDTH-1:0] ff1_o,
  output logic signed [COEFF_WIDTH-1:0] ff2_o,
  output logic signed [COEFF_WIDTH-1:0] fb1_o,
  output logic signed [COEFF_WIDTH-1:0] fb2_o
);

  localparam int unsigned CoeffFrac = COEFF_WIDTH - COEFF_INT_BITS;
  // Unity gain in the coefficient format.
  localparam logic [COEFF_WIDTH-1:0] CoeffOne =
    {{(COEFF_INT_BITS-1){1'b0}}, 1'b1, {CoeffFrac{1'b0}}};

  logic                   bypass_q;
  logic [COEFF_WIDTH-1:0] ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;

  // Register writes; indexes past the last register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
      ff0_q    <= CoeffOne;
      ff1_q    <= '0;
      ff2_q    <= '0;
      fb1_q    <= '0;
      fb2_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_BYPASS:    bypass_q <= cfg_data_i[0];
        CFG_FF_GAIN_0: ff0_q    <= cfg_data_i;
        CFG_FF_GAIN_1: ff1_q    <= cfg_data_i;
        CFG_FF_GAIN_2: ff2_q    <= cfg_data_i;
        CFG_FB_GAIN_1: fb1_q    <= cfg_data_i;
        CFG_FB_GAIN_2: fb2_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign bypass_o = bypass_q;
  assign ff0_o    = ff0_q;
  assign ff1_o    = ff1_q;
  assign ff2_o    = ff2_q;
  assign fb1_o    = fb1_q;
  assign fb2_o    = fb2_q;

endmodule

// ----- rtl/bqf_seq.sv -----
// Microcode sequencer: step counter, program ROM lookup and branch logic.
module bqf_seq import bqf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             word;

  // Fetch the control word of the current step.
  assign word = ucode_word(step_q);

  // Branch decision for the next step.
  always_comb begin
    step_d = word.target;
    unique case (word.jmp)
      JMP_GO: step_d = word.target;
      JMP_WAIT_IN: begin
        if (!status_i.in_valid) step_d = step_q;
      end
      JMP_IF_BYPASS: begin
        if (!status_i.bypass) step_d = step_q + 1'b1;
      end
      JMP_WAIT_OUT: begin
        if (status_i.out_busy) step_d = step_q;
      end
      default: step_d = STEP_IDLE;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = word;

endmodule

// ----- rtl/bqf_datapath.sv -----
// Datapath: shared multiplier, saturating adder, delay registers and output register.
module bqf_datapath import bqf_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COEFF_WIDTH  = COEFF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctrl_t                          ctrl_i,
  input  logic                           in_valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [COEFF_WIDTH-1:0]  ff0_i,
  input  logic signed [COEFF_WIDTH-1:0]  ff1_i,
  input  logic signed [COEFF_WIDTH-1:0]  ff2_i,
  input  logic signed [COEFF_WIDTH-1:0]  fb1_i,
  input  logic signed [COEFF_WIDTH-1:0]  fb2_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           clipped_o,
  output logic                           out_busy_o
);

  localparam int unsigned DelayW    = SAMPLE_WIDTH + COEFF_WIDTH;
  localparam int unsigned SumW      = DelayW + 2;
  localparam int unsigned CoeffFrac = COEFF_WIDTH - COEFF_INT_BITS;
  localparam int unsigned TopW      = DelayW - CoeffFrac - SAMPLE_WIDTH + 1;

  localparam logic signed [DelayW-1:0] DelayMax = {1'b0, {(DelayW-1){1'b1}}};
  localparam logic signed [DelayW-1:0] DelayMin = {1'b1, {(DelayW-1){1'b0}}};
  localparam logic signed [DelayW-1:0] RoundHalf =
    {{(DelayW-CoeffFrac){1'b0}}, 1'b1, {(CoeffFrac-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SampleMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SampleMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] x_q, y_q;
  logic                           clip_q;
  logic signed [DelayW-1:0]       prod_q, acc_q, d1_q, d2_q;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_clip_q;

  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [COEFF_WIDTH-1:0]  mul_b;
  logic signed [DelayW-1:0]       prod_d;
  logic signed [DelayW-1:0]       add_a, add_b;
  logic                           add_sub;
  logic signed [SumW-1:0]         sum_w;
  logic signed [DelayW-1:0]       sat_w;
  logic [TopW-1:0]                y_top;
  logic                           y_in_range;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           out_busy, out_load;

  // Clamp a widened sum back to the delay range.
  function automatic logic signed [DelayW-1:0] sat_delay(logic signed [SumW-1:0] v);
    logic [SumW-DelayW:0] top;
    top = v[SumW-1:DelayW-1];
    if (top == '0 || top == '1) begin
      return v[DelayW-1:0];
    end
    return v[SumW-1] ? DelayMin : DelayMax;
  endfunction

  // Multiplier operand selection.
  always_comb begin
    mul_a = x_q;
    mul_b = ff0_i;
    case (ctrl_i.mul)
      MUL_X_FF1: mul_b = ff1_i;
      MUL_X_FF2: mul_b = ff2_i;
      MUL_Y_FB1: begin
        mul_a = y_q;
        mul_b = fb1_i;
      end
      MUL_Y_FB2: begin
        mul_a = y_q;
        mul_b = fb2_i;
      end
      default: ;
    endcase
  end

  // The exact product always fits the delay width.
  assign prod_d = DelayW'(mul_a) * DelayW'(mul_b);

  // Adder operand selection.
  always_comb begin
    add_a   = prod_q;
    add_b   = d1_q;
    add_sub = 1'b0;
    case (ctrl_i.add)
      ADD_ACC_HALF: begin
        add_a = acc_q;
        add_b = RoundHalf;
      end
      ADD_PROD_D2: add_b = d2_q;
      ADD_D1_SUB: begin
        add_a   = d1_q;
        add_b   = prod_q;
        add_sub = 1'b1;
      end
      ADD_D2_SUB: begin
        add_a   = d2_q;
        add_b   = prod_q;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum_w = add_sub ? (SumW'(add_a) - SumW'(add_b)) : (SumW'(add_a) + SumW'(add_b));
  assign sat_w = sat_delay(sum_w);

  // Drop the fraction bits and saturate to the sample range.
  assign y_top      = acc_q[DelayW-1:CoeffFrac+SAMPLE_WIDTH-1];
  assign y_in_range = (y_top == '0) || (y_top == '1);
  assign y_sat      = y_in_range ? acc_q[CoeffFrac+SAMPLE_WIDTH-1:CoeffFrac]
                                 : (acc_q[DelayW-1] ? SampleMin : SampleMax);

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_in && in_valid_i) x_q <= sample_i;
    if (ctrl_i.mul != MUL_HOLD) prod_q <= prod_d;
    if (ctrl_i.add == ADD_PROD_D1 || ctrl_i.add == ADD_ACC_HALF) acc_q <= sat_w;
    case (ctrl_i.y_op)
      Y_ROUND: begin
        y_q    <= y_sat;
        clip_q <= !y_in_range;
      end
      Y_PASS: begin
        y_q    <= x_q;
        clip_q <= 1'b0;
      end
      default: ;
    endcase
  end

  // Filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      if (ctrl_i.add == ADD_PROD_D2 || ctrl_i.add == ADD_D1_SUB) d1_q <= sat_w;
      if (ctrl_i.d2_load) begin
        d2_q <= prod_q;
      end else if (ctrl_i.add == ADD_D2_SUB) begin
        d2_q <= sat_w;
      end
    end
  end

  // Output register: loads when empty or being emptied in the same cycle.
  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = ctrl_i.emit && !out_busy;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= y_q;
      out_clip_q   <= clip_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;
  assign out_busy_o   = out_busy;

endmodule

// ----- rtl/bqf_checker.sv -----
// Port-level assertion checker for the biquad IIR filter, bound to the top level.
module bqf_checker import bqf_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] sample_out_i,
  input logic                    clipped_i
);

  localparam logic [SAMPLE_WIDTH-1:0] SampleMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SampleMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // A waiting result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_out_i) && $stable(clipped_i))
    else $error("result payload changed while stalled");

  // One item is worked on at a time: ready drops right after an acceptance.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready again right after an item was taken");

  // A clipped result sits on one of the range limits.
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clipped_i |-> sample_out_i == SampleMax || sample_out_i == SampleMin)
    else $error("clipped result not at a range limit");

endmodule

bind biquad_iir_filter bqf_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bqf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sample_out_i(out_o.sample_out),
  .clipped_i   (out_o.clipped)
);
